/* sv/mph_pkg.sv */
// Shared types and constants for the MQTT PUBLISH header parser.
package mph_pkg;

  localparam logic [7:0] TYPE_MASK    = 8'hF0;
  localparam logic [7:0] TYPE_PUBLISH = 8'h30;
  localparam logic [7:0] LEN_MASK     = 8'h7F;
  localparam logic [7:0] CONT_BIT     = 8'h80;
  localparam logic [7:0] SLASH_CHAR   = 8'h2F;

  localparam logic [28:0] AFTER_MAX = 29'h1FFF_FFFF;
  localparam logic [27:0] PAY_MAX   = 28'hFFF_FFFF;

  typedef enum logic [3:0] {
    PH_TYPE  = 4'd0,
    PH_LEN   = 4'd1,
    PH_TLH   = 4'd2,
    PH_TLL   = 4'd3,
    PH_TOPIC = 4'd4,
    PH_IDH   = 4'd5,
    PH_IDL   = 4'd6,
    PH_PAY   = 4'd7,
    PH_IGN   = 4'd8
  } phase_t;

  typedef enum logic [2:0] {
    SEG_PREFIX = 3'd0,
    SEG_SYSTEM = 3'd1,
    SEG_TARGET = 3'd2,
    SEG_THIRD  = 3'd3,
    SEG_SUFFIX = 3'd4
  } seg_t;

  typedef enum logic [3:0] {
    ROLE_TYPE      = 4'd0,
    ROLE_LENGTH    = 4'd1,
    ROLE_TOPIC_LEN = 4'd2,
    ROLE_PREFIX    = 4'd3,
    ROLE_SLASH     = 4'd4,
    ROLE_SYSTEM    = 4'd5,
    ROLE_TARGET    = 4'd6,
    ROLE_SUFFIX    = 4'd7,
    ROLE_IDENT     = 4'd8,
    ROLE_PAYLOAD   = 4'd9,
    ROLE_IGNORED   = 4'd10
  } role_t;

  typedef enum logic [1:0] {
    ST_OK           = 2'd0,
    ST_NOT_PUBLISH  = 2'd1,
    ST_LEN_MISMATCH = 2'd2,
    ST_LEN_OVERLONG = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    FORM_NO_SLASH   = 2'd0,
    FORM_PREFIX     = 2'd1,
    FORM_TARGET     = 2'd2,
    FORM_SUFFIX     = 2'd3
  } form_t;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       packet_end;
  } item_t;

  typedef struct packed {
    logic [1:0]  topic_form;
    logic [27:0] payload_bytes;
    logic [15:0] topic_bytes;
    logic [15:0] packet_ident;
    logic        dup_flag;
    logic        retain_flag;
    logic [1:0]  qos_level;
    status_t     status;
    logic [7:0]  out_byte;
    role_t       byte_role;
    logic        packet_done;
  } result_t;

endpackage

/* sv/mph_in_reg.sv */
// Input register for the byte stream, loaded whenever it is empty or being drained.
module mph_in_reg (
  input  logic          clk,
  input  logic          rst,
  input  logic          s_axis_tvalid,
  output logic          s_axis_tready,
  input  logic [7:0]    s_axis_tdata,   // in_byte
  input  logic          s_axis_tlast,   // packet_end
  input  logic          take,
  output logic          item_valid,
  output mph_pkg::item_t item
);
  import mph_pkg::*;

  assign s_axis_tready = !item_valid || take;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (s_axis_tvalid && s_axis_tready) begin
      item_valid <= 1'b1;
    end else if (take) begin
      item_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      item.in_byte    <= s_axis_tdata;
      item.packet_end <= s_axis_tlast;
    end
  end

endmodule

/* sv/mph_core.sv */
// Parser state and the per-byte decode that produces one result.
module mph_core #(
  parameter int MAX_LENGTH_BYTES = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             fire,
  input  mph_pkg::item_t   item,
  output mph_pkg::result_t result
);
  import mph_pkg::*;

  localparam int LSW = $clog2(MAX_LENGTH_BYTES + 1);

  phase_t      phase, phase_next;
  logic [27:0] length_accum, length_accum_next;
  logic [LSW-1:0] length_shift, length_shift_next;
  logic [28:0] bytes_after_length, bytes_after_length_next;
  logic [15:0] topic_len_reg, topic_len_reg_next;
  logic [15:0] topic_count, topic_count_next;
  seg_t        segment_phase, segment_phase_next;
  logic [3:0]  header_flags, header_flags_next;
  logic [15:0] ident_reg, ident_reg_next;
  logic [27:0] payload_count, payload_count_next;
  status_t     error_code, error_code_next;

  logic [7:0]  b;
  logic        is_slash;
  logic [1:0]  len_idx;
  logic [27:0] len_group;
  phase_t      after_topic;
  status_t     st;
  logic [1:0]  form;
  role_t       role;

  assign b         = item.in_byte;
  assign is_slash  = (b == SLASH_CHAR);
  assign len_idx   = 2'(length_shift);
  assign len_group = {21'b0, b[6:0]} << (5'd7 * 5'(len_idx));

  always_comb begin
    phase_next              = phase;
    length_accum_next       = length_accum;
    length_shift_next       = length_shift;
    bytes_after_length_next = bytes_after_length;
    topic_len_reg_next      = topic_len_reg;
    topic_count_next        = topic_count;
    segment_phase_next      = segment_phase;
    header_flags_next       = header_flags;
    ident_reg_next          = ident_reg;
    payload_count_next      = payload_count;
    error_code_next         = error_code;
    role                    = ROLE_IGNORED;
    after_topic             = (header_flags[2:1] != 2'b00) ? PH_IDH : PH_PAY;

    if (phase inside {[PH_TLH:PH_PAY]} && bytes_after_length != AFTER_MAX) begin
      bytes_after_length_next = bytes_after_length + 29'd1;
    end

    case (phase)
      PH_TYPE: begin
        role = ROLE_TYPE;
        if ((b & TYPE_MASK) != TYPE_PUBLISH) begin
          error_code_next = ST_NOT_PUBLISH;
          phase_next      = PH_IGN;
        end else begin
          header_flags_next = b[3:0];
          phase_next        = PH_LEN;
        end
      end
      PH_LEN: begin
        role              = ROLE_LENGTH;
        length_accum_next = length_accum | len_group;
        length_shift_next = length_shift + LSW'(1);
        if ((b & CONT_BIT) != 8'h00) begin
          if (length_shift_next >= LSW'(MAX_LENGTH_BYTES)) begin
            error_code_next = ST_LEN_OVERLONG;
            phase_next      = PH_IGN;
          end
        end else begin
          phase_next = PH_TLH;
        end
      end
      PH_TLH: begin
        role               = ROLE_TOPIC_LEN;
        topic_len_reg_next = {b, 8'h00};
        phase_next         = PH_TLL;
      end
      PH_TLL: begin
        role               = ROLE_TOPIC_LEN;
        topic_len_reg_next = topic_len_reg | {8'h00, b};
        phase_next         = (topic_len_reg_next != 16'd0) ? PH_TOPIC : after_topic;
      end
      PH_TOPIC: begin
        case (segment_phase)
          SEG_PREFIX: begin
            if (is_slash) begin
              segment_phase_next = SEG_SYSTEM;
              role               = ROLE_SLASH;
            end else begin
              role = ROLE_PREFIX;
            end
          end
          SEG_SYSTEM: begin
            if (is_slash) begin
              segment_phase_next = SEG_TARGET;
              role               = ROLE_SLASH;
            end else begin
              role = ROLE_SYSTEM;
            end
          end
          SEG_TARGET: begin
            if (is_slash) begin
              segment_phase_next = SEG_THIRD;
              role               = ROLE_SLASH;
            end else begin
              role = ROLE_TARGET;
            end
          end
          default: begin
            segment_phase_next = SEG_SUFFIX;
            role               = ROLE_SUFFIX;
          end
        endcase
        topic_count_next = topic_count + 16'd1;
        if (topic_count_next == topic_len_reg) begin
          phase_next = after_topic;
        end
      end
      PH_IDH: begin
        role           = ROLE_IDENT;
        ident_reg_next = {b, 8'h00};
        phase_next     = PH_IDL;
      end
      PH_IDL: begin
        role           = ROLE_IDENT;
        ident_reg_next = ident_reg | {8'h00, b};
        phase_next     = PH_PAY;
      end
      PH_PAY: begin
        role = ROLE_PAYLOAD;
        if (payload_count != PAY_MAX) begin
          payload_count_next = payload_count + 28'd1;
        end
      end
      default: begin
        role = ROLE_IGNORED;
      end
    endcase

    // summary is taken from the updated state
    st = error_code_next;
    if (st == ST_OK &&
        (phase_next != PH_PAY || bytes_after_length_next != {1'b0, length_accum_next})) begin
      st = ST_LEN_MISMATCH;
    end

    case (segment_phase_next)
      SEG_PREFIX: form = FORM_NO_SLASH;
      SEG_SYSTEM: form = FORM_PREFIX;
      SEG_TARGET: form = FORM_TARGET;
      SEG_THIRD:  form = FORM_TARGET;
      default:    form = FORM_SUFFIX;
    endcase
  end

  always_comb begin
    result               = '0;
    result.out_byte      = b;
    result.byte_role     = role;
    result.packet_done   = item.packet_end;
    if (item.packet_end) begin
      result.status        = st;
      result.qos_level     = header_flags_next[2:1];
      result.retain_flag   = header_flags_next[0];
      result.dup_flag      = header_flags_next[3];
      result.packet_ident  = (header_flags_next[2:1] != 2'b00) ? ident_reg_next : 16'd0;
      result.topic_bytes   = topic_len_reg_next;
      result.payload_bytes = payload_count_next;
      result.topic_form    = form;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || (fire && item.packet_end)) begin
      phase              <= PH_TYPE;
      length_accum       <= '0;
      length_shift       <= '0;
      bytes_after_length <= '0;
      topic_len_reg      <= '0;
      topic_count        <= '0;
      segment_phase      <= SEG_PREFIX;
      header_flags       <= '0;
      ident_reg          <= '0;
      payload_count      <= '0;
      error_code         <= ST_OK;
    end else if (fire) begin
      phase              <= phase_next;
      length_accum       <= length_accum_next;
      length_shift       <= length_shift_next;
      bytes_after_length <= bytes_after_length_next;
      topic_len_reg      <= topic_len_reg_next;
      topic_count        <= topic_count_next;
      segment_phase      <= segment_phase_next;
      header_flags       <= header_flags_next;
      ident_reg          <= ident_reg_next;
      payload_count      <= payload_count_next;
      error_code         <= error_code_next;
    end
  end

  a_end_restarts: assert property (@(posedge clk) disable iff (rst)
    fire && item.packet_end |=> phase == PH_TYPE && length_accum == 28'd0)
    else $error("parser did not restart after last byte");

  a_shift_bound: assert property (@(posedge clk) disable iff (rst)
    length_shift <= LSW'(MAX_LENGTH_BYTES))
    else $error("length byte count past limit");

  a_error_ignores: assert property (@(posedge clk) disable iff (rst)
    error_code != ST_OK |-> phase == PH_IGN)
    else $error("error recorded while still parsing");

  a_ident_needs_qos: assert property (@(posedge clk) disable iff (rst)
    phase == PH_IDH |-> header_flags[2:1] != 2'b00)
    else $error("packet id expected with qos zero");

endmodule

/* sv/mph_out_reg.sv */
// Result register driving the master stream.
module mph_out_reg (
  input  logic             clk,
  input  logic             rst,
  input  logic             load,
  input  mph_pkg::result_t result,
  output logic             can_load,
  output logic             m_axis_tvalid,
  input  logic             m_axis_tready,
  output logic [79:0]      m_axis_tdata,  // out_byte, status, qos_level, retain_flag,
                                          // dup_flag, packet_ident, topic_bytes,
                                          // payload_bytes, topic_form, zero fill
  output logic [3:0]       m_axis_tuser,  // byte_role
  output logic             m_axis_tlast   // packet_done
);
  import mph_pkg::*;

  result_t res;

  assign can_load = !m_axis_tvalid || m_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (load) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  // hold payload until the next transfer is loaded
  always_ff @(posedge clk) begin
    if (load) begin
      res <= result;
    end
  end

  assign m_axis_tdata = {4'b0, res.topic_form, res.payload_bytes, res.topic_bytes,
                         res.packet_ident, res.dup_flag, res.retain_flag,
                         res.qos_level, res.status, res.out_byte};
  assign m_axis_tuser = res.byte_role;
  assign m_axis_tlast = res.packet_done;

endmodule

/* sv/mqtt_publish_header_parser_unit.sv */
// Top level of the MQTT PUBLISH header parser.
//
//  channel   direction  width          contents
//  s_axis    in         tdata 8        in_byte; tlast = packet_end
//  m_axis    out        tdata 80       out_byte..topic_form; tuser = byte_role;
//                                      tlast = packet_done
//
// One byte per cycle sustained while the output is not stalled; each byte passes
// through the input register and its result through the result register.
// The decode between them is a single pass of the phase and counter update.
// rst is synchronous and returns the parser to expecting a fixed header byte.
// A stalled output holds its result while one more byte waits in the input
// register; input ready drops only when both are full.
module mqtt_publish_header_parser_unit #(
  parameter int MAX_LENGTH_BYTES = 4
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // in_byte
  input  logic        s_axis_tlast,   // packet_end
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [79:0] m_axis_tdata,   // out_byte, status, qos_level, retain_flag, dup_flag,
                                      // packet_ident, topic_bytes, payload_bytes,
                                      // topic_form, zero fill
  output logic [3:0]  m_axis_tuser,   // byte_role
  output logic        m_axis_tlast    // packet_done
);
  import mph_pkg::*;

  item_t   item;
  logic    item_valid;
  logic    can_load;
  logic    fire;
  result_t result;

  assign fire = item_valid && can_load;

  mph_in_reg u_in_reg (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .take          (fire),
    .item_valid    (item_valid),
    .item          (item)
  );

  mph_core #(
    .MAX_LENGTH_BYTES (MAX_LENGTH_BYTES)
  ) u_core (
    .clk    (clk),
    .rst    (rst),
    .fire   (fire),
    .item   (item),
    .result (result)
  );

  mph_out_reg u_out_reg (
    .clk           (clk),
    .rst           (rst),
    .load          (fire),
    .result        (result),
    .can_load      (can_load),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

endmodule

/* tb/mph_result_checker.sv */
// Checker for the MQTT PUBLISH header parser: predicts each result and compares it.
`timescale 1ns / 1ps

module mph_result_checker #(
  parameter int MAX_LENGTH_BYTES = 4
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // in_byte
  input  logic        s_axis_tlast,   // packet_end
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [79:0] m_axis_tdata,   // out_byte, status, qos_level, retain_flag, dup_flag,
                                      // packet_ident, topic_bytes, payload_bytes,
                                      // topic_form, zero fill
  input  logic [3:0]  m_axis_tuser,   // byte_role
  input  logic        m_axis_tlast,   // packet_done
  output int          errors,
  output int          pending
);
  import mph_pkg::*;

  // Parser state as the predictor tracks it
  phase_t      ph;
  logic [27:0] len_acc;
  logic [2:0]  len_cnt;
  logic [28:0] after_len;
  logic [15:0] tlen;
  logic [15:0] tcount;
  seg_t        seg;
  logic [3:0]  flags;
  logic [15:0] ident;
  logic [27:0] pay_cnt;
  status_t     err;

  result_t     expected_results[$];
  int          err_count = 0;
  int          result_idx = 0;

  task automatic clear_parser();
    ph        = PH_TYPE;
    len_acc   = '0;
    len_cnt   = '0;
    after_len = '0;
    tlen      = '0;
    tcount    = '0;
    seg       = SEG_PREFIX;
    flags     = '0;
    ident     = '0;
    pay_cnt   = '0;
    err       = ST_OK;
  endtask

  task automatic parse_byte(input logic [7:0] b, input logic last, output result_t r);
    role_t   role;
    status_t st;
    logic    slash;
    role  = ROLE_IGNORED;
    slash = (b == SLASH_CHAR);
    if (ph >= PH_TLH && ph <= PH_PAY && after_len < AFTER_MAX)
      after_len = after_len + 29'd1;

    case (ph)
      PH_TYPE: begin
        role = ROLE_TYPE;
        if ((b & TYPE_MASK) != TYPE_PUBLISH) begin
          err = ST_NOT_PUBLISH;
          ph  = PH_IGN;
        end else begin
          flags = b[3:0];
          ph    = PH_LEN;
        end
      end
      PH_LEN: begin
        role    = ROLE_LENGTH;
        len_acc = len_acc | (28'(b & LEN_MASK) << (7 * len_cnt[1:0]));
        len_cnt = len_cnt + 3'd1;
        if ((b & CONT_BIT) == 8'h00) begin
          ph = PH_TLH;
        end else if (len_cnt >= MAX_LENGTH_BYTES) begin
          err = ST_LEN_OVERLONG;
          ph  = PH_IGN;
        end
      end
      PH_TLH: begin
        role = ROLE_TOPIC_LEN;
        tlen = {b, 8'h00};
        ph   = PH_TLL;
      end
      PH_TLL: begin
        role      = ROLE_TOPIC_LEN;
        tlen[7:0] = b;
        if (tlen != 16'd0)
          ph = PH_TOPIC;
        else
          ph = (flags[2:1] != 2'd0) ? PH_IDH : PH_PAY;
      end
      PH_TOPIC: begin
        // past the third slash everything is suffix, slashes included
        case (seg)
          SEG_PREFIX: begin
            if (slash) begin
              seg  = SEG_SYSTEM;
              role = ROLE_SLASH;
            end else
              role = ROLE_PREFIX;
          end
          SEG_SYSTEM: begin
            if (slash) begin
              seg  = SEG_TARGET;
              role = ROLE_SLASH;
            end else
              role = ROLE_SYSTEM;
          end
          SEG_TARGET: begin
            if (slash) begin
              seg  = SEG_THIRD;
              role = ROLE_SLASH;
            end else
              role = ROLE_TARGET;
          end
          default: begin
            seg  = SEG_SUFFIX;
            role = ROLE_SUFFIX;
          end
        endcase
        tcount = tcount + 16'd1;
        if (tcount == tlen)
          ph = (flags[2:1] != 2'd0) ? PH_IDH : PH_PAY;
      end
      PH_IDH: begin
        role  = ROLE_IDENT;
        ident = {b, 8'h00};
        ph    = PH_IDL;
      end
      PH_IDL: begin
        role       = ROLE_IDENT;
        ident[7:0] = b;
        ph         = PH_PAY;
      end
      PH_PAY: begin
        role = ROLE_PAYLOAD;
        if (pay_cnt < PAY_MAX)
          pay_cnt = pay_cnt + 28'd1;
      end
      default: role = ROLE_IGNORED;
    endcase

    r             = '0;
    r.out_byte    = b;
    r.byte_role   = role;
    r.packet_done = last;
    if (last) begin
      st = err;
      if (st == ST_OK && (ph != PH_PAY || after_len != {1'b0, len_acc}))
        st = ST_LEN_MISMATCH;
      r.status        = st;
      r.qos_level     = flags[2:1];
      r.retain_flag   = flags[0];
      r.dup_flag      = flags[3];
      r.packet_ident  = (flags[2:1] != 2'd0) ? ident : 16'd0;
      r.topic_bytes   = tlen;
      r.payload_bytes = pay_cnt;
      case (seg)
        SEG_PREFIX:            r.topic_form = FORM_NO_SLASH;
        SEG_SYSTEM:            r.topic_form = FORM_PREFIX;
        SEG_TARGET, SEG_THIRD: r.topic_form = FORM_TARGET;
        default:               r.topic_form = FORM_SUFFIX;
      endcase
      clear_parser();
    end
  endtask

  task automatic report_mismatch(input string msg);
    err_count++;
    if (err_count <= 40)
      $display("[%0t] mismatch: %s", $time, msg);
  endtask

  task automatic compare_field(input string name, input logic [27:0] got,
                               input logic [27:0] want);
    if (got !== want)
      report_mismatch($sformatf("result %0d %s got %0h want %0h",
                                result_idx, name, got, want));
  endtask

  always @(posedge clk) begin
    result_t predicted;
    result_t want;
    if (rst) begin
      clear_parser();
      expected_results.delete();
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        parse_byte(s_axis_tdata, s_axis_tlast, predicted);
        expected_results.push_back(predicted);
      end
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_results.size() == 0) begin
          report_mismatch($sformatf("result %0d arrived with nothing outstanding",
                                    result_idx));
        end else begin
          want = expected_results.pop_front();
          compare_field("out_byte",      28'(m_axis_tdata[7:0]),   28'(want.out_byte));
          compare_field("byte_role",     28'(m_axis_tuser),        28'(want.byte_role));
          compare_field("packet_done",   28'(m_axis_tlast),        28'(want.packet_done));
          compare_field("status",        28'(m_axis_tdata[9:8]),   28'(want.status));
          compare_field("qos_level",     28'(m_axis_tdata[11:10]), 28'(want.qos_level));
          compare_field("retain_flag",   28'(m_axis_tdata[12]),    28'(want.retain_flag));
          compare_field("dup_flag",      28'(m_axis_tdata[13]),    28'(want.dup_flag));
          compare_field("packet_ident",  28'(m_axis_tdata[29:14]), 28'(want.packet_ident));
          compare_field("topic_bytes",   28'(m_axis_tdata[45:30]), 28'(want.topic_bytes));
          compare_field("payload_bytes", m_axis_tdata[73:46],      want.payload_bytes);
          compare_field("topic_form",    28'(m_axis_tdata[75:74]), 28'(want.topic_form));
          compare_field("zero_fill",     28'(m_axis_tdata[79:76]), 28'd0);
        end
        result_idx++;
      end
    end
    errors  <= err_count;
    pending <= expected_results.size();
  end

endmodule

/* tb/mqtt_publish_header_parser_unit_test.sv */
// Testbench top for the MQTT PUBLISH header parser: packet stimulus and verdict.
`timescale 1ns / 1ps

module mqtt_publish_header_parser_unit_test;
  import mph_pkg::*;

  localparam int MAX_LEN_BYTES  = 4;
  localparam int RANDOM_ITEMS   = 1250;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DIRECTED_N     = 27;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = 8'h00;
  logic        s_axis_tlast = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [79:0] m_axis_tdata;
  logic [3:0]  m_axis_tuser;
  logic        m_axis_tlast;

  int          errors;
  int          pending;
  int          items_sent = 0;
  int          idle_cycles = 0;
  int          rx_hold = 0;
  int          rx_mode_left = 0;
  bit          rx_steady = 1'b0;

  logic [7:0]  pkt[$];

  // wrong type; overlong length; end inside the length field; full qos 3 packet
  // with a zero topic byte and a slash in the suffix; zero topic with a bad count
  logic [7:0] directed_bytes [DIRECTED_N] = '{
    8'h20,
    8'h31, 8'h80, 8'hFF, 8'h80, 8'h80, 8'h55,
    8'h32, 8'h85,
    8'h3F, 8'h0C, 8'h00, 8'h07, 8'h61, 8'h2F, 8'h00, 8'h2F, 8'h63, 8'h2F, 8'h2F,
    8'h12, 8'h34, 8'hFF,
    8'h30, 8'h03, 8'h00, 8'h00
  };
  bit directed_last [DIRECTED_N] = '{
    1'b1,
    1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1,
    1'b0, 1'b1,
    1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0,
    1'b0, 1'b0, 1'b1,
    1'b0, 1'b0, 1'b0, 1'b1
  };

  always #10 clk = ~clk;

  mqtt_publish_header_parser_unit #(
    .MAX_LENGTH_BYTES(MAX_LEN_BYTES)
  ) u_top (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  mph_result_checker #(
    .MAX_LENGTH_BYTES(MAX_LEN_BYTES)
  ) u_checker (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .errors        (errors),
    .pending       (pending)
  );

  // mostly short gaps, now and then a long one
  function automatic int gap_len();
    if ($urandom_range(0, 9) < 8)
      return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic send_byte(input logic [7:0] b, input logic last, input bit burst);
    int gap;
    gap = 0;
    if (!burst && $urandom_range(0, 2) == 0)
      gap = gap_len();
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tlast  <= last;
    do @(posedge clk); while (!s_axis_tready);
    items_sent++;
  endtask

  // Build one PUBLISH packet; len_delta skews the encoded remaining length,
  // min_groups sets the least number of length bytes, which can force a non-minimal encoding.
  task automatic gen_publish(input logic [3:0] flags, input int tlen, input int pay_len,
                             input int len_delta, input int min_groups);
    int rem;
    int n;
    int pick;
    rem = 2 + tlen + pay_len + ((flags[2:1] != 2'd0) ? 2 : 0) + len_delta;
    if (rem < 0)
      rem = 0;
    if (rem > 32'h0FFF_FFFF)
      rem = 32'h0FFF_FFFF;
    pkt.push_back({4'h3, flags});
    n = 0;
    do begin
      n++;
      pkt.push_back({(rem > 127 || n < min_groups), 7'(rem)});
      rem = rem >> 7;
    end while (rem != 0 || n < min_groups);
    pkt.push_back(8'(tlen >> 8));
    pkt.push_back(8'(tlen));
    for (int i = 0; i < tlen; i++) begin
      pick = $urandom_range(0, 9);
      if (pick < 3)
        pkt.push_back(SLASH_CHAR);
      else if (pick == 3)
        pkt.push_back(8'h00);
      else if (pick < 7)
        pkt.push_back(8'h61 + 8'($urandom_range(0, 25)));
      else
        pkt.push_back(8'($urandom));
    end
    if (flags[2:1] != 2'd0) begin
      pkt.push_back(8'($urandom));
      pkt.push_back(8'($urandom));
    end
    repeat (pay_len) pkt.push_back(8'($urandom));
  endtask

  always @(posedge clk) begin
    if (rx_mode_left == 0) begin
      rx_mode_left <= $urandom_range(50, 300);
      rx_steady    <= ($urandom_range(0, 9) < 3);
    end else
      rx_mode_left <= rx_mode_left - 1;
    if (rx_hold != 0) begin
      rx_hold       <= rx_hold - 1;
      m_axis_tready <= 1'b0;
    end else if (!rx_steady && $urandom_range(0, 3) == 0) begin
      rx_hold       <= gap_len() - 1;
      m_axis_tready <= 1'b0;
    end else
      m_axis_tready <= 1'b1;
  end

  // count cycles with no transfer on either side
  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end else
      idle_cycles <= idle_cycles + 1;
  end

  initial begin
    int         kind;
    int         roll;
    int         tlen;
    int         pay;
    int         minb;
    int         delta;
    int         cut;
    int         tnib;
    bit         burst;
    logic [3:0] hdr;
    logic [7:0] junk;

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    for (int i = 0; i < DIRECTED_N; i++)
      send_byte(directed_bytes[i], directed_last[i], 1'b0);

    while (items_sent < RANDOM_ITEMS) begin
      pkt.delete();
      kind = $urandom_range(0, 99);
      hdr  = 4'($urandom);
      roll = $urandom_range(0, 99);
      if (roll < 10)
        tlen = 0;
      else if (roll < 11)
        tlen = $urandom_range(256, 300);
      else
        tlen = $urandom_range(1, 12);
      pay  = ($urandom_range(0, 19) == 0) ? $urandom_range(20, 60) : $urandom_range(0, 8);
      minb = ($urandom_range(0, 4) == 0) ? $urandom_range(1, MAX_LEN_BYTES) : 1;

      if (kind < 60) begin
        gen_publish(hdr, tlen, pay, 0, minb);
      end else if (kind < 70) begin
        // remaining length off by a little or by a lot
        if ($urandom_range(0, 3) == 0)
          delta = $urandom_range(1000, 268000000);
        else
          delta = $urandom_range(1, 3);
        if ($urandom_range(0, 1) == 1)
          delta = -delta;
        gen_publish(hdr, tlen, pay, delta, minb);
      end else if (kind < 80) begin
        // drop the tail of a good packet
        gen_publish(hdr, tlen, pay, 0, minb);
        cut = $urandom_range(1, pkt.size() - 1);
        while (pkt.size() > cut)
          junk = pkt.pop_back();
      end else if (kind < 85) begin
        tnib = $urandom_range(0, 14);
        if (tnib >= 3)
          tnib++;
        pkt.push_back({4'(tnib), 4'($urandom)});
        repeat ($urandom_range(0, 5)) pkt.push_back(8'($urandom));
      end else if (kind < 90) begin
        pkt.push_back({4'h3, hdr});
        repeat (MAX_LEN_BYTES) pkt.push_back(CONT_BIT | 8'($urandom));
        repeat ($urandom_range(0, 3)) pkt.push_back(8'($urandom));
      end else begin
        if ($urandom_range(0, 1) == 1)
          pkt.push_back({4'h3, hdr});
        else
          pkt.push_back(8'($urandom));
        repeat ($urandom_range(0, 7)) pkt.push_back(8'($urandom));
      end

      burst = ($urandom_range(0, 9) < 3);
      for (int i = 0; i < pkt.size(); i++)
        send_byte(pkt[i], (i == pkt.size() - 1), burst);
    end
    s_axis_tvalid <= 1'b0;

    // let the checker count the last transfer before polling pending
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (errors == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

endmodule

/* files.f */
sv/mph_pkg.sv
sv/mph_in_reg.sv
sv/mph_core.sv
sv/mph_out_reg.sv
sv/mqtt_publish_header_parser_unit.sv
tb/mph_result_checker.sv
tb/mqtt_publish_header_parser_unit_test.sv
